// ===== rtl/cts_pkg.sv =====
// shared types and constants of the convection term stencil
package cts_pkg;

	localparam int CNT_BITS       = 10;
	localparam int CNT_LIMIT      = 1024;
	localparam int CFG_BITS       = 11;
	localparam int FRAC_BITS      = 28;
	localparam int OUT_BITS       = 48;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_VALUE_BITS = 32;
	localparam int SIZE_RESET     = 64;
	localparam int ADDR_BITS      = 3;

	typedef enum logic [0:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] cell_u;
		logic signed [31:0] cell_v;
		logic signed [31:0] face_u_left;
		logic signed [31:0] face_v_down;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] conv_x;
		logic signed [OUT_BITS-1:0] conv_y;
		logic [CNT_BITS-1:0]        out_col;
		logic [CNT_BITS-1:0]        out_row;
		logic                       saturated;
		logic                       last_of_run;
	} out_item_t;

endpackage

// ===== rtl/convection_term_stencil_core.sv =====
// Convection term stencil over a staggered 2D cavity grid with a two-row
// store in one synchronous memory. Cells go in raster order. The block
// works on one cell at a time: bookkeeping to accept and store the cell,
// plus for each result it produces a pick of the cell, the 5 neighborhood
// reads through the single read port, 8 passes through the face-times-sum
// and scale multipliers, and the handover to the output register, which
// waits while the consumer is not ready. Row 0 gives no result; a later row
// gives the result of the cell below; the top row also finishes itself one
// cell behind, and also its own last cell. A register write restarts the
// frame. Output holds one result and may wait for the consumer while the
// next cell is taken.
module convection_term_stencil_core #(
	parameter int MAX_WIDTH  = cts_pkg::DEF_MAX_WIDTH,
	parameter int VALUE_BITS = cts_pkg::DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cts_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cts_pkg::out_item_t          out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cts_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import cts_pkg::*;

	localparam int IB    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int DEPTH = 2 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int WMAX  = (MAX_WIDTH < CNT_LIMIT) ? MAX_WIDTH : CNT_LIMIT;
	localparam int SB    = 34;
	localparam int PB    = 66;
	localparam int HB    = 36;
	localparam int AB    = 52;
	localparam logic signed [SB-1:0] LID_TWO = SB'(64'sd2 <<< FRAC_BITS);
	localparam logic signed [AB-1:0] OMAX = AB'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
	localparam logic signed [AB-1:0] OMIN = AB'(-(64'sd1 <<< (OUT_BITS - 1)));

	typedef struct packed {
		logic signed [IB-1:0] u;
		logic signed [IB-1:0] v;
		logic signed [IB-1:0] fu;
		logic signed [IB-1:0] fv;
	} cell_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_GATHER = 5'b00010,
		ST_CALC   = 5'b00100,
		ST_EMIT   = 5'b01000,
		ST_STORE  = 5'b10000
	} state_t;

	// neighborhood slots
	localparam int NB_C = 0;
	localparam int NB_W = 1;
	localparam int NB_E = 2;
	localparam int NB_S = 3;
	localparam int NB_N = 4;

	state_t               state_q;
	logic [CFG_BITS-1:0]  grid_width_q, grid_height_q;
	logic [CFG_BITS-1:0]  eff_w, eff_h;
	logic [CNT_BITS-1:0]  col_q, row_q, cur_col_q, cur_row_q;
	cell_t                cur_q;
	logic [2:0]           pend_q;
	logic [CNT_BITS-1:0]  em_i_q, em_j_q;
	logic                 em_last_q;
	cell_t                nb_q [5];
	logic [2:0]           gk_q;
	logic                 hit_q;
	logic [3:0]           tk_q;
	logic signed [HB-1:0] hp_s1;
	logic                 v_s1, neg_s1, useh_s1, vld_s1;
	logic signed [AB-1:0] acc_x_q, acc_y_q;
	out_item_t            out_q;
	logic                 out_valid_q;
	cell_t                mem [DEPTH];
	cell_t                rdata_q;

	// configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		if (grid_width_q < CFG_BITS'(2)) eff_w = CFG_BITS'(2);
		else if (grid_width_q > CFG_BITS'(WMAX)) eff_w = CFG_BITS'(WMAX);
		else eff_w = grid_width_q;
		if (grid_height_q < CFG_BITS'(2)) eff_h = CFG_BITS'(2);
		else if (grid_height_q > CFG_BITS'(CNT_LIMIT)) eff_h = CFG_BITS'(CNT_LIMIT);
		else eff_h = grid_height_q;
	end

	// job decode at acceptance
	logic       in_acc, top_row;
	logic [2:0] pend_new;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign top_row   = (CFG_BITS'(row_q) == eff_h - CFG_BITS'(1));
	assign pend_new  = {top_row && (CFG_BITS'(col_q) == eff_w - CFG_BITS'(1)),
		top_row && (col_q != '0), row_q != '0};

	// next emit in raster order: cell below, cell to the left, current cell
	logic [CNT_BITS-1:0] sel_i, sel_j;
	logic [2:0]          sel_rest;
	always_comb begin
		priority if (pend_q[0]) begin
			sel_i = cur_col_q;
			sel_j = cur_row_q - CNT_BITS'(1);
			sel_rest = {pend_q[2:1], 1'b0};
		end else if (pend_q[1]) begin
			sel_i = cur_col_q - CNT_BITS'(1);
			sel_j = cur_row_q;
			sel_rest = {pend_q[2], 2'b00};
		end else begin
			sel_i = cur_col_q;
			sel_j = cur_row_q;
			sel_rest = 3'b000;
		end
	end

	// walls around the emitted cell
	logic w_wall, e_wall, s_wall, n_wall;
	assign w_wall = (em_i_q == '0);
	assign e_wall = (CFG_BITS'(em_i_q) == eff_w - CFG_BITS'(1));
	assign s_wall = (em_j_q == '0);
	assign n_wall = (CFG_BITS'(em_j_q) == eff_h - CFG_BITS'(1));

	// neighbor address for the gather step
	logic [CNT_BITS-1:0] n_row, n_col;
	logic [AW-1:0]       raddr, waddr;
	always_comb begin
		n_row = em_j_q;
		n_col = em_i_q;
		unique case (gk_q)
			3'd1:    n_col = em_i_q - CNT_BITS'(1);
			3'd2:    n_col = em_i_q + CNT_BITS'(1);
			3'd3:    n_row = em_j_q - CNT_BITS'(1);
			3'd4:    n_row = em_j_q + CNT_BITS'(1);
			default: ;
		endcase
	end
	assign raddr = n_row[0] ? AW'(MAX_WIDTH + int'(n_col)) : AW'(n_col);
	assign waddr = cur_row_q[0] ? AW'(MAX_WIDTH + int'(cur_col_q)) : AW'(cur_col_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_STORE)
			mem[waddr] <= cur_q;
		rdata_q <= mem[raddr];
	end

	// one flux term per cycle
	logic signed [SB-1:0] cval, nval, sum, face;
	logic signed [PB-1:0] prod;
	logic                 t_v;
	logic [1:0]           t_k;
	assign t_v = tk_q[2];
	assign t_k = tk_q[1:0];
	always_comb begin
		cval = t_v ? SB'(nb_q[NB_C].v) : SB'(nb_q[NB_C].u);
		unique case (t_k)
			2'd0: begin
				nval = e_wall ? -cval : (t_v ? SB'(nb_q[NB_E].v) : SB'(nb_q[NB_E].u));
				face = e_wall ? '0 : SB'(nb_q[NB_E].fu);
			end
			2'd1: begin
				nval = w_wall ? -cval : (t_v ? SB'(nb_q[NB_W].v) : SB'(nb_q[NB_W].u));
				face = SB'(nb_q[NB_C].fu);
			end
			2'd2: begin
				if (n_wall) nval = t_v ? -cval : LID_TWO - cval;
				else nval = t_v ? SB'(nb_q[NB_N].v) : SB'(nb_q[NB_N].u);
				face = n_wall ? '0 : SB'(nb_q[NB_N].fv);
			end
			default: begin
				nval = s_wall ? -cval : (t_v ? SB'(nb_q[NB_S].v) : SB'(nb_q[NB_S].u));
				face = SB'(nb_q[NB_C].fv);
			end
		endcase
		sum  = cval + nval;
		prod = PB'(face) * PB'(sum);
	end

	logic signed [AB-1:0] scaled;
	logic [CFG_BITS-1:0]  scale;
	assign scale  = useh_s1 ? eff_h : eff_w;
	assign scaled = AB'(hp_s1) * AB'($signed({1'b0, scale}));

	// saturation
	logic sat_x, sat_y;
	logic signed [OUT_BITS-1:0] res_x, res_y;
	always_comb begin
		sat_x = (acc_x_q > OMAX) || (acc_x_q < OMIN);
		sat_y = (acc_y_q > OMAX) || (acc_y_q < OMIN);
		res_x = (acc_x_q > OMAX) ? OUT_BITS'(OMAX) :
			(acc_x_q < OMIN) ? OUT_BITS'(OMIN) : OUT_BITS'(acc_x_q);
		res_y = (acc_y_q > OMAX) ? OUT_BITS'(OMAX) :
			(acc_y_q < OMIN) ? OUT_BITS'(OMIN) : OUT_BITS'(acc_y_q);
	end

	logic out_free;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q.u  <= IB'(in_data.cell_u);
			cur_q.v  <= IB'(in_data.cell_v);
			cur_q.fu <= IB'(in_data.face_u_left);
			cur_q.fv <= IB'(in_data.face_v_down);
			cur_col_q <= col_q;
			cur_row_q <= row_q;
		end
		if (state_q == ST_GATHER) begin
			hit_q <= (n_row == cur_row_q) && (n_col == cur_col_q);
			if (gk_q != '0)
				nb_q[gk_q - 3'd1] <= hit_q ? cur_q : rdata_q;
		end
		hp_s1   <= prod[HB+28:29];
		v_s1    <= t_v;
		neg_s1  <= t_k[0];
		useh_s1 <= t_k[1];
		if (state_q == ST_GATHER) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (vld_s1) begin
			if (v_s1) acc_y_q <= neg_s1 ? acc_y_q - scaled : acc_y_q + scaled;
			else acc_x_q <= neg_s1 ? acc_x_q - scaled : acc_x_q + scaled;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q.conv_x      <= res_x;
			out_q.conv_y      <= res_y;
			out_q.out_col     <= em_i_q;
			out_q.out_row     <= em_j_q;
			out_q.saturated   <= sat_x || sat_y;
			out_q.last_of_run <= em_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			grid_width_q  <= CFG_BITS'(SIZE_RESET);
			grid_height_q <= CFG_BITS'(SIZE_RESET);
			col_q         <= '0;
			row_q         <= '0;
			pend_q        <= '0;
			em_i_q        <= '0;
			em_j_q        <= '0;
			em_last_q     <= 1'b0;
			gk_q          <= '0;
			tk_q          <= '0;
			vld_s1        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_CALC) && !tk_q[3];
			if (state_q == ST_EMIT && gk_q != 3'd7 && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				unique case (reg_idx_t'(paddr[2]))
					REG_GRID_WIDTH:  grid_width_q  <= pwdata[CFG_BITS-1:0];
					REG_GRID_HEIGHT: grid_height_q <= pwdata[CFG_BITS-1:0];
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (in_acc) begin
				if (CFG_BITS'(col_q) + CFG_BITS'(1) >= eff_w) begin
					col_q <= '0;
					row_q <= top_row ? '0 : row_q + CNT_BITS'(1);
				end else begin
					col_q <= col_q + CNT_BITS'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pend_q <= pend_new;
						state_q <= (pend_new != '0) ? ST_EMIT : ST_STORE;
						// entering the emit state with gk_q at 7 makes its first pass select a cell
						em_last_q <= 1'b0;
						gk_q <= 3'd7;
					end
				end
				ST_GATHER: begin
					gk_q <= gk_q + 3'd1;
					if (gk_q == 3'd5) begin
						tk_q <= '0;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (!tk_q[3]) tk_q <= tk_q + 4'd1;
					else if (!vld_s1) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// first pass selects a cell, later passes hand out its result
					if (gk_q == 3'd7) begin
						em_i_q <= sel_i;
						em_j_q <= sel_j;
						em_last_q <= (sel_rest == '0);
						pend_q <= sel_rest;
						gk_q <= '0;
						state_q <= ST_GATHER;
					end else if (out_free) begin
						gk_q <= 3'd7;
						state_q <= (pend_q != '0) ? ST_EMIT : ST_STORE;
					end
				end
				ST_STORE: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (CFG_BITS'(col_q) < eff_w))
		else $error("column counter beyond grid width");
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (CFG_BITS'(row_q) < eff_h))
		else $error("row counter beyond grid height");
	a_calc_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC && tk_q == 4'd0) |=> (tk_q == 4'd1))
		else $error("term sequencer stalled");
`endif

endmodule
